[hw/rtl/scyt_pkg.sv]
`default_nettype none

package scyt_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned KEY_W = 7;
  localparam int unsigned CFG_W = 7;
  localparam int unsigned REG_IDX_W = 1;
  localparam int unsigned SUM_W = ((LEN_W > KEY_W) ? LEN_W : KEY_W) + 1;
  localparam int unsigned DIV_CNT_W = (LEN_W > 1) ? $clog2(LEN_W) : 1;

  localparam logic [REG_IDX_W-1:0] REG_KEY_SIZE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_DECRYPT_MODE = 1'b1;

  typedef enum logic [1:0] {
    STEP_LOAD,
    STEP_SETUP,
    STEP_DIV,
    STEP_EMIT
  } step_t;

  typedef enum logic [1:0] {
    COND_LAST_IN,
    COND_DECRYPT,
    COND_DIV_DONE,
    COND_EMIT_DONE
  } cond_t;

  typedef struct packed {
    logic in_en;
    logic setup;
    logic div_step;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic last_in;
    logic decrypt;
    logic div_done;
    logic emit_done;
  } status_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t on_true;
    step_t on_false;
  } uword_t;

  // Control store: one word per step of the program.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '0;
    unique case (s)
      STEP_LOAD: begin
        w.ctrl.in_en = 1'b1;
        w.cond = COND_LAST_IN;
        w.on_true = STEP_SETUP;
        w.on_false = STEP_LOAD;
      end
      STEP_SETUP: begin
        w.ctrl.setup = 1'b1;
        w.cond = COND_DECRYPT;
        w.on_true = STEP_DIV;
        w.on_false = STEP_EMIT;
      end
      STEP_DIV: begin
        w.ctrl.div_step = 1'b1;
        w.cond = COND_DIV_DONE;
        w.on_true = STEP_EMIT;
        w.on_false = STEP_DIV;
      end
      STEP_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond = COND_EMIT_DONE;
        w.on_true = STEP_LOAD;
        w.on_false = STEP_EMIT;
      end
      default: begin
        w.cond = COND_LAST_IN;
        w.on_true = STEP_LOAD;
        w.on_false = STEP_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/scytale_transposition.sv]
// Scytale transposition of one message at a time.
// Input channel: in_byte/in_last under in_valid/in_stall, one transfer per
// cycle while loading; in_last marks the final byte. Up to 64 bytes are
// kept; later bytes are dropped and every result of that message carries
// out_truncated.
// Output channel: out_byte/out_last/out_truncated under out_valid/out_stall.
// out_last marks the final result of the message.
// Configuration: wr_en/wr_index/wr_data; index 0 is the key size (0 acts as
// 1), index 1 selects decryption. Values held in the registers at the setup
// step that follows the last byte are used for that message.
// Order: after the last input transfer the sequencer runs its setup step,
// then, when decrypting, a divide of the length by the key, then emission.
// During emission, results follow at one per cycle while the receiver does
// not stall, set by the single read port of the message store. in_stall
// stays high from the last input transfer until the final result has
// entered the output register.
// A stalled receiver holds the output register and pauses the emission.
// Reset clears the sequencer, the length, the overflow flag and the
// registers (key size 1, encryption); the store itself is not cleared.
`default_nettype none

module scytale_transposition (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_last,
  output logic                            out_truncated,
  input  logic                            wr_en,
  input  logic [scyt_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [scyt_pkg::CFG_W-1:0]      wr_data
);

  scyt_pkg::ctrl_t   ctrl;
  scyt_pkg::status_t status;

  scyt_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  scyt_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .status        (status),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_truncated (out_truncated),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data)
  );

endmodule

`default_nettype wire

[hw/rtl/scyt_div.sv]
`default_nettype none

module scyt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          step,
  input  logic [scyt_pkg::LEN_W-1:0]    dividend,
  input  logic [scyt_pkg::KEY_W-1:0]    divisor,
  output logic [scyt_pkg::LEN_W-1:0]    quo,
  output logic [scyt_pkg::KEY_W-1:0]    rem,
  output logic                          done
);

  logic [scyt_pkg::KEY_W-1:0]     dvs;
  logic [scyt_pkg::DIV_CNT_W-1:0] cnt;
  logic [scyt_pkg::KEY_W:0]       rem_shift;
  logic                           fits;

  always_comb begin
    rem_shift = {rem, quo[scyt_pkg::LEN_W-1]};
    fits = rem_shift >= {1'b0, dvs};
    done = step && (cnt == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= scyt_pkg::DIV_CNT_W'(scyt_pkg::LEN_W - 1);
    end else if (step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (step) begin
      if (fits) begin
        rem <= scyt_pkg::KEY_W'(rem_shift - {1'b0, dvs});
      end else begin
        rem <= rem_shift[scyt_pkg::KEY_W-1:0];
      end
      quo <= {quo[scyt_pkg::LEN_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/scyt_datapath.sv]
`default_nettype none

module scyt_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  scyt_pkg::ctrl_t                 ctrl,
  output scyt_pkg::status_t               status,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_last,
  output logic                            out_truncated,
  input  logic                            wr_en,
  input  logic [scyt_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [scyt_pkg::CFG_W-1:0]      wr_data
);

  localparam int unsigned LW = scyt_pkg::LEN_W;
  localparam int unsigned AW = scyt_pkg::ADDR_W;
  localparam int unsigned KW = scyt_pkg::KEY_W;
  localparam int unsigned SW = scyt_pkg::SUM_W;

  logic [7:0]    store [scyt_pkg::MAX_LEN];
  logic [KW-1:0] key_size;
  logic          decrypt_mode;
  logic [KW-1:0] key_eff;
  logic [KW-1:0] key;
  logic          mode;
  logic [LW-1:0] msg_len;
  logic          overflow;
  logic          in_acc;
  logic          has_room;

  logic [LW-1:0] pos;
  logic [LW-1:0] face;
  logic [LW-1:0] idx;
  logic [LW-1:0] f;
  logic [LW-1:0] m;
  logic [LW-1:0] j;

  logic [LW-1:0] quo;
  logic [KW-1:0] rem;
  logic          div_done;

  logic [SW-1:0] pos_sum;
  logic          wrap_e;
  logic [SW-1:0] f_inc;
  logic          wrap_d;
  logic          f_lt_r;
  logic [SW-1:0] j_sum;
  logic [AW-1:0] rd_addr;
  logic          issue;
  logic          last_item;

  scyt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.setup),
    .step     (ctrl.div_step),
    .dividend (msg_len),
    .divisor  (key_eff),
    .quo      (quo),
    .rem      (rem),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= KW'(1);
      decrypt_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        scyt_pkg::REG_KEY_SIZE: key_size <= wr_data[KW-1:0];
        scyt_pkg::REG_DECRYPT_MODE: decrypt_mode <= wr_data[0];
        default: key_size <= key_size;
      endcase
    end
  end

  always_comb begin
    key_eff = (key_size == '0) ? KW'(1) : key_size;
    in_stall = !ctrl.in_en;
    in_acc = in_valid && !in_stall;
    has_room = SW'(msg_len) < SW'(scyt_pkg::MAX_LEN);

    pos_sum = SW'(pos) + SW'(key);
    wrap_e = pos_sum >= SW'(msg_len);

    f_inc = SW'(f) + SW'(1);
    wrap_d = f_inc == SW'(key);
    f_lt_r = SW'(f) < SW'(rem);
    j_sum = SW'(j) + SW'(quo) + SW'(f_lt_r);

    rd_addr = mode ? j[AW-1:0] : pos[AW-1:0];
    issue = ctrl.emit && (!out_valid || !out_stall);
    last_item = (SW'(idx) + SW'(1)) == SW'(msg_len);

    status.last_in = in_acc && in_last;
    status.decrypt = decrypt_mode;
    status.div_done = div_done;
    status.emit_done = issue && last_item;
  end

  always_ff @(posedge clk) begin
    if (in_acc && has_room) begin
      store[msg_len[AW-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_len <= '0;
      overflow <= 1'b0;
    end else if (status.emit_done) begin
      msg_len <= '0;
      overflow <= 1'b0;
    end else if (in_acc) begin
      if (has_room) begin
        msg_len <= msg_len + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.setup) begin
      key <= key_eff;
      mode <= decrypt_mode;
      pos <= '0;
      face <= '0;
      idx <= '0;
      f <= '0;
      m <= '0;
      j <= '0;
    end else if (issue) begin
      idx <= idx + 1'b1;
      if (wrap_e) begin
        face <= face + 1'b1;
        pos <= face + 1'b1;
      end else begin
        pos <= pos_sum[LW-1:0];
      end
      if (wrap_d) begin
        f <= '0;
        m <= m + 1'b1;
        j <= m + 1'b1;
      end else begin
        f <= f_inc[LW-1:0];
        j <= j_sum[LW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_byte <= store[rd_addr];
      out_last <= last_item;
      out_truncated <= overflow;
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    SW'(msg_len) <= SW'(scyt_pkg::MAX_LEN))
    else $error("stored length exceeds capacity");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> (SW'(rd_addr) < SW'(msg_len)))
    else $error("read address beyond the stored message");

  a_setup_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.setup |-> (msg_len != '0))
    else $error("emission started with an empty store");

  a_valid_from_issue: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.emit))
    else $error("result appeared outside the emission step");
`endif

endmodule

`default_nettype wire

[hw/rtl/scyt_seq.sv]
`default_nettype none

module scyt_seq (
  input  logic              clk,
  input  logic              rst,
  input  scyt_pkg::status_t status,
  output scyt_pkg::ctrl_t   ctrl
);

  scyt_pkg::step_t  pc;
  scyt_pkg::step_t  pc_next;
  scyt_pkg::uword_t word;
  logic             taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= scyt_pkg::STEP_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    word = scyt_pkg::ucode(pc);
    ctrl = word.ctrl;
    unique case (word.cond)
      scyt_pkg::COND_LAST_IN:   taken = status.last_in;
      scyt_pkg::COND_DECRYPT:   taken = status.decrypt;
      scyt_pkg::COND_DIV_DONE:  taken = status.div_done;
      scyt_pkg::COND_EMIT_DONE: taken = status.emit_done;
      default:                  taken = 1'b0;
    endcase
    pc_next = taken ? word.on_true : word.on_false;
  end

endmodule

`default_nettype wire
